// ===== src/ptd_pkg.sv =====
`default_nettype none

package ptd_pkg;

    // Defaults for the top-level timing parameters.
    localparam int TICKS_PER_CYCLE_DEFAULT        = 50000;
    localparam int MICROSECONDS_PER_CYCLE_DEFAULT = 20000;

    // Reset values of the configuration registers.
    localparam logic [15:0] COUNTER_TOP_RESET      = 16'd55000;
    localparam logic [15:0] LOCK_WINDOW_RESET      = 16'd1666;
    localparam logic [15:0] PULSE_END_MARGIN_RESET = 16'd1000;

    localparam logic [7:0]  DELAY_BYTE_RESET = 8'hFF;
    localparam logic [15:0] DELAY_FORCE_OFF  = 16'hFFFF;
    localparam logic [15:0] DELAY_FORCE_ON   = 16'h0000;

    // Configuration register indexes.
    localparam logic [1:0] REG_COUNTER_TOP      = 2'd0;
    localparam logic [1:0] REG_LOCK_WINDOW      = 2'd1;
    localparam logic [1:0] REG_PULSE_END_MARGIN = 2'd2;

    typedef enum logic [2:0] {
        CMD_TICK       = 3'd0,
        CMD_ZERO_CROSS = 3'd1,
        CMD_ADDR_MATCH = 3'd2,
        CMD_BUS_WRITE  = 3'd3,
        CMD_BUS_READ   = 3'd4,
        CMD_BUS_STOP   = 3'd5
    } ptd_cmd_t;

    typedef enum logic [1:0] {
        MODE_PHASE = 2'd0,
        MODE_ON    = 2'd1,
        MODE_OFF   = 2'd2
    } ptd_mode_t;

    typedef struct packed {
        logic [15:0] counter_top;
        logic [15:0] lock_window;
        logic [15:0] pulse_end_margin;
    } ptd_cfg_t;

endpackage

`default_nettype wire

// ===== src/ptd_scaler.sv =====
`default_nettype none

module ptd_scaler #(
    parameter int TICKS_PER_CYCLE        = ptd_pkg::TICKS_PER_CYCLE_DEFAULT,
    parameter int MICROSECONDS_PER_CYCLE = ptd_pkg::MICROSECONDS_PER_CYCLE_DEFAULT
) (
    input  wire [15:0]  delay_us,
    output logic [15:0] ticks
);
    // The quotient delay * TICKS_PER_CYCLE / MICROSECONDS_PER_CYCLE is formed by
    // one multiplication with a rounded-up reciprocal scaled by 2^SHIFT. With
    // 2^SHIFT at least 2^16 times the divisor, the rounding error stays below
    // one divisor step for any 16-bit delay, so the truncated result is exact.
    // The reciprocal is a constant, so the multiplier reduces to shifts and adds.
    localparam int SHIFT  = 16 + $clog2(MICROSECONDS_PER_CYCLE);
    localparam int PROD_W = SHIFT + 16;

    localparam logic [63:0] TICKS_W   = 64'(TICKS_PER_CYCLE);
    localparam logic [63:0] DIVISOR_W = 64'(MICROSECONDS_PER_CYCLE);
    localparam logic [63:0] RECIP     = ((TICKS_W << SHIFT) + DIVISOR_W - 64'd1) / DIVISOR_W;
    localparam logic [PROD_W-1:0] RECIP_P = PROD_W'(RECIP);

    logic [PROD_W-1:0] product;

    assign product = PROD_W'(delay_us) * RECIP_P;
    assign ticks   = product[PROD_W-1:SHIFT];

endmodule

`default_nettype wire

// ===== src/ptd_core.sv =====
`default_nettype none

module ptd_core #(
    parameter int TICKS_PER_CYCLE = ptd_pkg::TICKS_PER_CYCLE_DEFAULT
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  ptd_pkg::ptd_cfg_t       cfg,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  wire [2:0]              in_command,
    input  wire [7:0]              in_bus_byte,
    output logic                   out_valid,
    input  wire                    out_ready,
    output logic                   out_triac_drive,
    output logic [7:0]             out_read_data,
    output logic                   out_synchronized,
    output logic [15:0]            scale_delay,
    input  wire  [15:0]            scale_ticks
);
    import ptd_pkg::*;

    localparam logic [15:0] PERIOD      = 16'(TICKS_PER_CYCLE);
    localparam logic [15:0] HALF_PERIOD = 16'(TICKS_PER_CYCLE / 2);
    localparam logic [16:0] PERIOD_EXT  = 17'(TICKS_PER_CYCLE);

    // Input register.
    logic     item_valid_reg;
    ptd_cmd_t item_cmd_reg;
    logic [7:0] item_byte_reg;

    // Dimmer state.
    logic [7:0]  delay_hi_reg, delay_hi_next;
    logic [7:0]  delay_lo_reg, delay_lo_next;
    logic        pointer_reg, pointer_next;
    logic        changed_reg, changed_next;
    logic        bus_busy_reg, bus_busy_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] fire_first_reg;
    logic [15:0] fire_second_reg;
    logic [15:0] off_cmp_reg, off_cmp_next;
    ptd_mode_t   mode_reg, mode_next;
    logic        oos_reg, oos_next;
    logic        gate_reg, gate_next;

    // Result register.
    logic       out_valid_reg;
    logic       res_gate_reg;
    logic [7:0] res_data_reg;
    logic       res_sync_reg;

    logic        advance;
    logic        start_phase;
    logic [7:0]  read_byte;
    logic [15:0] delay_word;
    logic [16:0] zc_diff;
    logic [16:0] zc_err;

    // An item moves on whenever the result register is free or being emptied.
    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;

    always_comb begin
        delay_hi_next = delay_hi_reg;
        delay_lo_next = delay_lo_reg;
        pointer_next  = pointer_reg;
        changed_next  = changed_reg;
        bus_busy_next = bus_busy_reg;
        count_next    = count_reg;
        off_cmp_next  = off_cmp_reg;
        mode_next     = mode_reg;
        oos_next      = oos_reg;
        gate_next     = gate_reg;
        read_byte     = '0;
        start_phase   = 1'b0;
        delay_word    = '0;

        zc_diff = {1'b0, count_reg} - PERIOD_EXT;
        zc_err  = zc_diff[16] ? (17'd0 - zc_diff) : zc_diff;

        case (item_cmd_reg)
            CMD_TICK: begin
                if (count_reg >= cfg.counter_top) begin
                    count_next = '0;
                    oos_next   = 1'b1;
                end else begin
                    count_next = count_reg + 16'd1;
                end
                // Matches are applied in order, so the pulse end wins.
                if (mode_reg == MODE_PHASE) begin
                    if (count_next == fire_first_reg) begin
                        off_cmp_next = HALF_PERIOD - cfg.pulse_end_margin;
                        gate_next    = 1'b1;
                    end
                    if (count_next == fire_second_reg) begin
                        off_cmp_next = PERIOD - cfg.pulse_end_margin;
                        gate_next    = 1'b1;
                    end
                    if (count_next == off_cmp_reg) begin
                        gate_next = 1'b0;
                    end
                end
            end
            CMD_ZERO_CROSS: begin
                if (oos_reg || (zc_err <= {1'b0, cfg.lock_window})) begin
                    count_next = '0;
                    oos_next   = 1'b0;
                end
            end
            CMD_ADDR_MATCH: begin
                pointer_next  = 1'b0;
                bus_busy_next = 1'b1;
            end
            CMD_BUS_WRITE: begin
                if (pointer_reg) begin
                    delay_lo_next = item_byte_reg;
                end else begin
                    delay_hi_next = item_byte_reg;
                end
                changed_next = 1'b1;
                pointer_next = !pointer_reg;
            end
            CMD_BUS_READ: begin
                read_byte    = pointer_reg ? delay_lo_reg : delay_hi_reg;
                pointer_next = !pointer_reg;
            end
            CMD_BUS_STOP: begin
                bus_busy_next = 1'b0;
            end
            default: begin
            end
        endcase

        // A new delay takes effect once the bus transfer has ended.
        if (changed_next && !bus_busy_next) begin
            changed_next = 1'b0;
            delay_word   = {delay_hi_next, delay_lo_next};
            if (delay_word == DELAY_FORCE_ON) begin
                mode_next = MODE_ON;
                gate_next = 1'b1;
            end else if (delay_word == DELAY_FORCE_OFF) begin
                mode_next = MODE_OFF;
                gate_next = 1'b0;
            end else begin
                mode_next   = MODE_PHASE;
                start_phase = 1'b1;
            end
        end
    end

    assign scale_delay = delay_word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            delay_hi_reg    <= DELAY_BYTE_RESET;
            delay_lo_reg    <= DELAY_BYTE_RESET;
            pointer_reg     <= 1'b0;
            changed_reg     <= 1'b1;
            bus_busy_reg    <= 1'b0;
            count_reg       <= '0;
            fire_first_reg  <= '0;
            fire_second_reg <= '0;
            off_cmp_reg     <= '0;
            mode_reg        <= MODE_OFF;
            oos_reg         <= 1'b1;
            gate_reg        <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                item_valid_reg <= 1'b1;
            end else if (advance) begin
                item_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end

            if (advance) begin
                delay_hi_reg <= delay_hi_next;
                delay_lo_reg <= delay_lo_next;
                pointer_reg  <= pointer_next;
                changed_reg  <= changed_next;
                bus_busy_reg <= bus_busy_next;
                count_reg    <= count_next;
                off_cmp_reg  <= off_cmp_next;
                mode_reg     <= mode_next;
                oos_reg      <= oos_next;
                gate_reg     <= gate_next;
                if (start_phase) begin
                    fire_first_reg  <= scale_ticks;
                    fire_second_reg <= scale_ticks + HALF_PERIOD;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_cmd_reg  <= ptd_cmd_t'(in_command);
            item_byte_reg <= in_bus_byte;
        end
        if (advance) begin
            res_gate_reg <= gate_next;
            res_data_reg <= read_byte;
            res_sync_reg <= !oos_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_triac_drive  = res_gate_reg;
    assign out_read_data    = res_data_reg;
    assign out_synchronized = res_sync_reg;

endmodule

`default_nettype wire

// ===== src/phase_angle_triac_dimmer.sv =====
// An accepted word waits in the input register until the result register is
// free or being emptied, and then its result word is presented from there.
// Throughput: one word per clock while results are taken, for every command; a
// new phase delay is scaled to ticks in the same cycle as the word applying it.
// Reset is synchronous on aresetn low and restores the valid flags, the state
// and config registers to reset values; the gate is off, the counter unlocked.
`default_nettype none

module phase_angle_triac_dimmer #(
    parameter int TICKS_PER_CYCLE        = ptd_pkg::TICKS_PER_CYCLE_DEFAULT,
    parameter int MICROSECONDS_PER_CYCLE = ptd_pkg::MICROSECONDS_PER_CYCLE_DEFAULT
) (
    input  wire        aclk,
    input  wire        aresetn,

    // Input stream: one event word per transfer.
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [7:0]  s_tdata,   // [7:0] bus_byte
    input  wire [2:0]  s_tuser,   // [2:0] command

    // Result stream: one result word per input word.
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [15:0] m_tdata,  // [0] triac_drive, [8:1] read_data,
                                  // [9] synchronized, [15:10] zero

    // Configuration writes.
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire [1:0]  cfg_index,
    input  wire [15:0] cfg_data
);
    import ptd_pkg::*;

    ptd_cfg_t    cfg_reg;
    logic [15:0] scale_delay;
    logic [15:0] scale_ticks;

    logic       res_gate;
    logic [7:0] res_data;
    logic       res_sync;

    // The configuration registers accept a write on every cycle. An index
    // past the last register is accepted and has no effect.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.counter_top      <= COUNTER_TOP_RESET;
            cfg_reg.lock_window      <= LOCK_WINDOW_RESET;
            cfg_reg.pulse_end_margin <= PULSE_END_MARGIN_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_COUNTER_TOP:      cfg_reg.counter_top      <= cfg_data;
                REG_LOCK_WINDOW:      cfg_reg.lock_window      <= cfg_data;
                REG_PULSE_END_MARGIN: cfg_reg.pulse_end_margin <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The core holds the tick counter, the bus register file and the gate
    // logic between an input register and a result register. A new phase
    // delay is turned into tick compares by the scaler, which forms
    // delay * TICKS_PER_CYCLE / MICROSECONDS_PER_CYCLE with a single constant
    // reciprocal multiplication, so the compares load with the applying word.
    ptd_core #(
        .TICKS_PER_CYCLE(TICKS_PER_CYCLE)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_command      (s_tuser),
        .in_bus_byte     (s_tdata),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_triac_drive (res_gate),
        .out_read_data   (res_data),
        .out_synchronized(res_sync),
        .scale_delay     (scale_delay),
        .scale_ticks     (scale_ticks)
    );

    ptd_scaler #(
        .TICKS_PER_CYCLE       (TICKS_PER_CYCLE),
        .MICROSECONDS_PER_CYCLE(MICROSECONDS_PER_CYCLE)
    ) u_scaler (
        .delay_us(scale_delay),
        .ticks   (scale_ticks)
    );

    // Result fields packed from the lowest bit up, padded to two bytes.
    assign m_tdata = {6'd0, res_sync, res_data, res_gate};

endmodule

`default_nettype wire
